// File: hdl/bpre_pkg.sv
// Shared types and constants for the binary proof record encoder.
// No dependencies; imported by every module of the block.
package bpre_pkg;

    // Input command codes
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_DEL   = 3'd1;
    localparam logic [2:0] CMD_LIT   = 3'd2;
    localparam logic [2:0] CMD_HINT  = 3'd3;
    localparam logic [2:0] CMD_END   = 3'd4;

    // Proof formats
    localparam logic [1:0] FMT_DRAT  = 2'd0;
    localparam logic [1:0] FMT_LRAT  = 2'd1;
    localparam logic [1:0] FMT_FRAT  = 2'd2;
    localparam logic [1:0] FMT_NONE  = 2'd3;
    localparam logic [1:0] FMT_RESET = FMT_FRAT;

    // Configuration register indexes
    localparam logic REG_FORMAT = 1'b0;

    // Record tags
    localparam logic [7:0] TAG_ADD   = 8'h61;
    localparam logic [7:0] TAG_DEL   = 8'h64;
    localparam logic [7:0] TAG_HINTS = 8'h6C;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // Varint layout
    localparam int FOLD_W  = 33;
    localparam int GROUP_W = 7;

    // Open record kind (one-hot)
    typedef enum logic [2:0] {
        KIND_NONE = 3'b001,
        KIND_ADD  = 3'b010,
        KIND_DEL  = 3'b100
    } kind_t;

    // One unit of output work: up to three fixed bytes, then an optional varint
    typedef struct packed {
        logic [1:0]        pre_n;
        logic [7:0]        pre0;
        logic [7:0]        pre1;
        logic [7:0]        pre2;
        logic              has_int;
        logic [FOLD_W-1:0] folded;
        logic              done;
    } job_t;

endpackage

// File: hdl/bpre_front.sv
// Front end: accepts proof tokens, tracks record state, emits byte jobs.
// Depends on bpre_pkg.
module bpre_front
    import bpre_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  proof_format,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // value
    input  logic [2:0]  s_tuser,    // cmd
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    kind_t kind_reg, kind_next;
    logic  hint_reg, hint_next;
    logic  lit_reg, lit_next;
    logic  ecs_reg, ecs_next;
    logic  supp_reg, supp_next;

    logic              s_fire;
    logic              on;
    logic              is_add;
    logic [32:0]       mag;
    logic [FOLD_W-1:0] folded;
    job_t              job;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;
    assign on       = !supp_reg && (proof_format != FMT_NONE);
    assign is_add   = (s_tuser == CMD_ADD);

    // Sign fold: 2x for x >= 0, 2|x|+1 otherwise
    assign mag = 33'h1_0000_0000 - {1'b0, s_tdata};
    assign folded = s_tdata[31] ? {mag[31:0], 1'b1} : {s_tdata, 1'b0};

    // Token classification and record state update
    always_comb begin
        kind_next = kind_reg;
        hint_next = hint_reg;
        lit_next  = lit_reg;
        ecs_next  = ecs_reg;
        supp_next = supp_reg;
        job         = '0;
        job.folded  = folded;
        case (s_tuser)
            CMD_ADD, CMD_DEL: begin
                kind_next = is_add ? KIND_ADD : KIND_DEL;
                hint_next = 1'b0;
                lit_next  = 1'b0;
                supp_next = ecs_reg && (is_add || proof_format != FMT_FRAT);
                if (!supp_next && proof_format != FMT_NONE) begin
                    job.pre_n   = 2'd1;
                    job.pre0    = is_add ? TAG_ADD : TAG_DEL;
                    job.has_int = (proof_format == FMT_FRAT) ||
                                  (is_add && proof_format == FMT_LRAT);
                end
            end
            CMD_LIT: begin
                if (kind_reg != KIND_NONE && !hint_reg) begin
                    if (kind_reg == KIND_ADD) begin
                        lit_next = 1'b1;
                    end
                    job.has_int = on &&
                        !(kind_reg == KIND_DEL && proof_format == FMT_LRAT);
                end
            end
            CMD_HINT: begin
                if (kind_reg != KIND_NONE) begin
                    hint_next = 1'b1;
                    if (on) begin
                        if (kind_reg == KIND_ADD && proof_format != FMT_DRAT) begin
                            // first hint closes the literal list
                            if (!hint_reg) begin
                                job.pre0  = BYTE_ZERO;
                                job.pre1  = TAG_HINTS;
                                job.pre_n = (proof_format == FMT_FRAT) ? 2'd2 : 2'd1;
                            end
                            job.has_int = 1'b1;
                        end else if (kind_reg == KIND_DEL &&
                                     proof_format == FMT_LRAT) begin
                            job.has_int = 1'b1;
                        end
                    end
                end
            end
            CMD_END: begin
                if (kind_reg != KIND_NONE) begin
                    if (on) begin
                        job.done = 1'b1;
                        if (kind_reg == KIND_ADD && proof_format != FMT_DRAT &&
                                !hint_reg) begin
                            if (proof_format == FMT_FRAT) begin
                                job.pre0  = BYTE_ZERO;
                                job.pre1  = TAG_HINTS;
                                job.pre2  = BYTE_ZERO;
                                job.pre_n = 2'd3;
                            end else begin
                                job.pre0  = BYTE_ZERO;
                                job.pre1  = BYTE_ZERO;
                                job.pre_n = 2'd2;
                            end
                        end else begin
                            job.pre0  = BYTE_ZERO;
                            job.pre_n = 2'd1;
                        end
                    end
                    if (kind_reg == KIND_ADD && !lit_reg &&
                            proof_format != FMT_NONE) begin
                        ecs_next = 1'b1;
                    end
                    kind_next = KIND_NONE;
                    hint_next = 1'b0;
                    lit_next  = 1'b0;
                    supp_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign q_job  = job;
    assign q_push = s_fire && (job.pre_n != 2'd0 || job.has_int);

    // Record state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_NONE;
            hint_reg <= 1'b0;
            lit_reg  <= 1'b0;
            ecs_reg  <= 1'b0;
            supp_reg <= 1'b0;
        end else if (s_fire) begin
            kind_reg <= kind_next;
            hint_reg <= hint_next;
            lit_reg  <= lit_next;
            ecs_reg  <= ecs_next;
            supp_reg <= supp_next;
        end
    end

endmodule

// File: hdl/bpre_queue.sv
// Short job queue between the front end and the byte serializer.
// Depends on bpre_pkg.
module bpre_queue
    import bpre_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/bpre_back.sv
// Back end: serializes one job into bytes, fixed bytes first, then the varint.
// Depends on bpre_pkg.
module bpre_back
    import bpre_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic       m_tlast,     // last_byte
    output logic       m_tuser      // record_done
);

    logic              busy_reg, busy_next;
    job_t              job_reg;
    logic [1:0]        idx_reg;
    logic [FOLD_W-1:0] val_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    logic       in_pre;
    logic       more;
    logic [7:0] pre_byte;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       adv;
    logic       load;

    // Current byte of the active job
    assign in_pre = (idx_reg < job_reg.pre_n);
    assign more   = (val_reg[FOLD_W-1:GROUP_W] != '0);

    always_comb begin
        case (idx_reg)
            2'd0:    pre_byte = job_reg.pre0;
            2'd1:    pre_byte = job_reg.pre1;
            2'd2:    pre_byte = job_reg.pre2;
            default: pre_byte = BYTE_ZERO;
        endcase
    end

    assign cur_byte = in_pre ? pre_byte : {more, val_reg[GROUP_W-1:0]};
    assign cur_last = in_pre ? ((idx_reg == job_reg.pre_n - 2'd1) && !job_reg.has_int)
                             : !more;

    // Advance when the output register is free or being drained
    assign adv   = busy_reg && (!out_valid_reg || m_tready);
    assign load  = q_valid && (!busy_reg || (adv && cur_last));
    assign q_pop = load;

    always_comb begin
        busy_next = busy_reg;
        if (adv && cur_last) begin
            busy_next = 1'b0;
        end
        if (load) begin
            busy_next = 1'b1;
        end
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job and output payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
            out_done_reg <= cur_last && job_reg.done;
        end
        if (load) begin
            job_reg <= q_job;
            idx_reg <= 2'd0;
            val_reg <= q_job.folded;
        end else if (adv) begin
            if (in_pre) begin
                idx_reg <= idx_reg + 2'd1;
            end else begin
                val_reg <= val_reg >> GROUP_W;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

// File: hdl/binary_proof_record_encoder_unit.sv
// Top level of the binary proof record encoder: APB format register, front end,
// job queue and byte serializer. Depends on bpre_pkg and the bpre_* modules.
//
// Turns proof tokens (add/delete start, literal, hint, record end) into binary
// DRAT, LRAT or FRAT bytes, one output item per byte, tlast on the last byte a
// token causes and tuser on the zero byte that closes a record. A token makes
// 0 to 7 bytes (a varint is 1 to 5 bytes): the serializer sends one byte per
// cycle while the receiver is ready, so that byte loop sets the rate. Tokens
// that make no bytes push no job. Tokens are accepted while the job queue
// (QUEUE_DEPTH entries) has room; an accepted token's bytes pass through the job
// queue and the serializer's job and output registers. proof_format sits at
// address 0 and resets to FRAT.
module binary_proof_record_encoder_unit
    import bpre_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)(
    input  logic        aclk,
    input  logic        aresetn,
    // token input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [2:0]  s_tuser,    // [2:0] cmd
    // byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // last_byte
    output logic        m_tuser,    // [0] record_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] fmt_reg;
    logic       cfg_wr;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    job_t       push_job;
    job_t       head_job;

    // Format register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else if (cfg_wr && paddr[2] == REG_FORMAT) begin
            fmt_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FORMAT) ? {30'd0, fmt_reg} : 32'd0;

    bpre_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .proof_format (fmt_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    bpre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    bpre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: test/binary_proof_record_encoder_unit_tb.sv
// Testbench for binary_proof_record_encoder_unit: proof tokens go in, and every output
// byte is checked against a byte encoder model kept inside this file.
// Depends on bpre_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module binary_proof_record_encoder_unit_tb;
    import bpre_pkg::*;

    localparam logic [2:0] FORMAT_ADDR = {REG_FORMAT, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } proof_byte_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] value
    logic [2:0]  s_tuser  = '0;    // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;
    logic        m_tuser;          // [0] record_done
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Encoder model state
    logic [1:0]  fmt_q       = FMT_RESET;
    kind_t       rec_kind    = KIND_NONE;
    logic        in_hints    = 1'b0;
    logic        has_lit     = 1'b0;
    logic        empty_seen  = 1'b0;
    logic        suppressed  = 1'b0;

    proof_byte_t proof_bytes_due[$];
    proof_byte_t token_bytes[$];
    int          mismatch_count = 0;
    int          stall_left     = 0;
    bit          quiet          = 1'b0;
    bit          protect_empty  = 1'b1;

    binary_proof_record_encoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // ---------------- byte encoder model ----------------

    function automatic void put_byte(input logic [7:0] b, input logic done);
        token_bytes.push_back('{data: b, last: 1'b0, done: done});
    endfunction

    // sign fold (2x or 2|x|+1), then little-endian base-128 groups
    function automatic void put_varint(input logic [31:0] v);
        logic [31:0] mag;
        logic [32:0] u;
        mag = v[31] ? (~v + 32'd1) : v;
        u = {mag, v[31]};
        while (u >= 33'd128) begin
            put_byte({1'b1, u[6:0]}, 1'b0);
            u = u >> 7;
        end
        put_byte(u[7:0], 1'b0);
    endfunction

    function automatic void encode_token(input logic [2:0] cmd, input logic [31:0] value);
        logic        on;
        logic        first;
        proof_byte_t b;
        token_bytes.delete();
        on = !suppressed && fmt_q != FMT_NONE;
        case (cmd)
            CMD_ADD, CMD_DEL: begin
                if (cmd == CMD_ADD) begin
                    rec_kind = KIND_ADD;
                    suppressed = empty_seen;
                end else begin
                    rec_kind = KIND_DEL;
                    suppressed = empty_seen && fmt_q != FMT_FRAT;
                end
                in_hints = 1'b0;
                has_lit = 1'b0;
                if (!suppressed && fmt_q != FMT_NONE) begin
                    put_byte((cmd == CMD_ADD) ? TAG_ADD : TAG_DEL, 1'b0);
                    if (fmt_q == FMT_FRAT || (cmd == CMD_ADD && fmt_q == FMT_LRAT))
                        put_varint(value);
                end
            end
            CMD_LIT: begin
                if (rec_kind != KIND_NONE && !in_hints) begin
                    if (rec_kind == KIND_ADD)
                        has_lit = 1'b1;
                    if (on && !(rec_kind == KIND_DEL && fmt_q == FMT_LRAT))
                        put_varint(value);
                end
            end
            CMD_HINT: begin
                if (rec_kind != KIND_NONE) begin
                    first = !in_hints;
                    in_hints = 1'b1;
                    if (on) begin
                        if (rec_kind == KIND_ADD && fmt_q != FMT_DRAT) begin
                            // first hint closes the literal list
                            if (first) begin
                                put_byte(BYTE_ZERO, 1'b0);
                                if (fmt_q == FMT_FRAT)
                                    put_byte(TAG_HINTS, 1'b0);
                            end
                            put_varint(value);
                        end else if (rec_kind == KIND_DEL && fmt_q == FMT_LRAT) begin
                            put_varint(value);
                        end
                    end
                end
            end
            CMD_END: begin
                if (rec_kind != KIND_NONE) begin
                    if (on) begin
                        if (rec_kind == KIND_ADD && fmt_q != FMT_DRAT && !in_hints) begin
                            put_byte(BYTE_ZERO, 1'b0);
                            if (fmt_q == FMT_FRAT)
                                put_byte(TAG_HINTS, 1'b0);
                        end
                        put_byte(BYTE_ZERO, 1'b1);
                    end
                    if (rec_kind == KIND_ADD && !has_lit && fmt_q != FMT_NONE)
                        empty_seen = 1'b1;
                    rec_kind = KIND_NONE;
                    in_hints = 1'b0;
                    has_lit = 1'b0;
                    suppressed = 1'b0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < token_bytes.size(); i++) begin
            b = token_bytes[i];
            b.last = (i == token_bytes.size() - 1);
            proof_bytes_due.push_back(b);
        end
    endfunction

    // ---------------- drivers ----------------

    // Sends one item; valid stays high afterwards until the next item or wait_idle.
    task automatic send_token(input logic [2:0] cmd, input logic [31:0] value);
        // keep the sticky empty-clause flag clear until the last phase
        if (protect_empty && cmd == CMD_END && rec_kind == KIND_ADD && !has_lit
                && fmt_q != FMT_NONE)
            cmd = CMD_DEL;
        if (!quiet && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        encode_token(cmd, value);
    endtask

    // Drops valid, waits for every expected byte, then lets the pipe settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (proof_bytes_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_format(input logic [1:0] f);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FORMAT_ADDR;
        pwdata  <= {30'd0, f};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        fmt_q = f;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0001;
            2: return 32'h8000_0000;
            3: return 32'd0;
            4, 5: return $urandom();
            6: return $urandom_range(0, 2000) - 32'd1000 + 32'd8192;
            default: return $urandom_range(0, 400) - 32'd200;
        endcase
    endfunction

    // Mostly well-formed records with random content, some broken or noise.
    task automatic send_record();
        int n_lits;
        int n_hints;
        if ($urandom_range(0, 9) == 0) begin
            send_token(3'($urandom_range(0, 7)), rand_value());
            return;
        end
        send_token(($urandom_range(0, 2) != 0) ? CMD_ADD : CMD_DEL, rand_value());
        n_lits = $urandom_range(protect_empty ? 1 : 0, 4);
        repeat (n_lits) send_token(CMD_LIT, rand_value());
        n_hints = $urandom_range(0, 3);
        repeat (n_hints) send_token(CMD_HINT, rand_value());
        if (n_hints != 0 && $urandom_range(0, 4) == 0)
            send_token(CMD_LIT, rand_value());
        // occasionally left open, to be abandoned by the next start
        if ($urandom_range(0, 9) != 0)
            send_token(CMD_END, rand_value());
    endtask

    // ---------------- result side ----------------

    // Random receiver stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 17);
        end
    end

    always @(posedge aclk) begin
        proof_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (proof_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected byte: data %h last %b done %b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                want = proof_bytes_due.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last
                        || m_tuser !== want.done) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("byte mismatch: expected %h/%b/%b, got %h/%b/%b (data/last/done)",
                                 want.data, want.last, want.done, m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    // ---------------- tests ----------------

    // Reset format is FRAT; value extremes, hints, and tokens with no record open
    task automatic test_frat_extremes();
        send_token(CMD_ADD,  32'd5);
        send_token(CMD_LIT,  32'h7FFF_FFFF);
        send_token(CMD_LIT,  32'h8000_0001);
        send_token(CMD_LIT,  32'h8000_0000);
        send_token(CMD_LIT,  32'd64);
        send_token(CMD_HINT, 32'd0);
        send_token(CMD_HINT, 32'hFFFF_FFFD);
        send_token(CMD_LIT,  32'd9);       // after a hint: ignored
        send_token(CMD_END,  32'd0);
        send_token(CMD_LIT,  32'd1);       // nothing open
        send_token(CMD_HINT, 32'd2);
        send_token(CMD_END,  32'd0);
        send_token(CMD_END + 3'd1, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    // LRAT delete ids, then a format change in the middle of an add
    task automatic test_lrat_and_switch();
        write_format(FMT_LRAT);
        send_token(CMD_DEL,  32'd77);
        send_token(CMD_LIT,  32'd3);       // ignored in LRAT delete
        send_token(CMD_HINT, 32'd4);
        send_token(CMD_END,  32'd0);
        send_token(CMD_ADD,  32'd2);
        send_token(CMD_LIT,  32'hFFFF_FFFB);
        wait_idle();
        write_format(FMT_FRAT);
        send_token(CMD_HINT, 32'd8);
        send_token(CMD_END,  32'd0);
        wait_idle();
    endtask

    // DRAT drops hints, a start over an open record; format none emits nothing
    task automatic test_drat_and_none();
        write_format(FMT_DRAT);
        send_token(CMD_ADD,  32'd1);
        send_token(CMD_LIT,  32'd1);
        send_token(CMD_HINT, 32'd2);
        send_token(CMD_DEL,  32'd6);
        send_token(CMD_LIT,  32'hFFFF_FFFF);
        send_token(CMD_HINT, 32'd3);
        send_token(CMD_END,  32'd0);
        wait_idle();
        write_format(FMT_NONE);
        protect_empty = 1'b0;
        send_token(CMD_ADD,  32'd3);
        send_token(CMD_END,  32'd0);       // empty clause, but not recorded
        protect_empty = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_formats();
        logic [1:0] order [8];
        order = '{FMT_DRAT, FMT_NONE, FMT_LRAT, FMT_FRAT,
                  FMT_LRAT, FMT_DRAT, FMT_FRAT, FMT_LRAT};
        for (int p = 0; p < 8; p++) begin
            write_format(order[p]);
            quiet = (p == 3);
            repeat (6) send_record();
            wait_idle();
        end
        quiet = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_stall();
        write_format(FMT_FRAT);
        stall_left = 150;
        repeat (6) send_record();
        wait_idle();
    endtask

    // Empty clause: later adds are suppressed, deletes only outside FRAT
    task automatic test_empty_clause();
        logic [1:0] order [5];
        order = '{FMT_DRAT, FMT_FRAT, FMT_LRAT, FMT_NONE, FMT_FRAT};
        write_format(FMT_LRAT);
        protect_empty = 1'b0;
        send_token(CMD_ADD,  32'd11);
        send_token(CMD_HINT, 32'd12);
        send_token(CMD_LIT,  32'd13);      // after a hint: does not count
        send_token(CMD_END,  32'd0);
        wait_idle();
        for (int p = 0; p < 5; p++) begin
            write_format(order[p]);
            repeat (4) send_record();
            wait_idle();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_frat_extremes();
        test_lrat_and_switch();
        test_drat_and_none();
        test_random_formats();
        test_output_stall();
        test_empty_clause();
        if (mismatch_count == 0 && proof_bytes_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
